// ----- sv/svft_pkg.sv -----
// Shared types, constants and the microcode program of the state variable filter.
package svft_pkg;

   // Default parameter values.
   localparam int SAMPLE_WIDTH_DEF   = 24;
   localparam int COEF_FRAC_BITS_DEF = 16;

   // Fixed datapath widths.
   localparam int STATE_W = 32;
   localparam int COEF_W  = 18;
   localparam int G_W     = 18;
   localparam int DAMP_W  = 18;
   localparam int NORM_W  = 17;

   // Register port.
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 4;
   localparam int REG_IDX_W  = 2;

   localparam logic [REG_IDX_W-1:0] REG_G    = 2'd0;
   localparam logic [REG_IDX_W-1:0] REG_DAMP = 2'd1;
   localparam logic [REG_IDX_W-1:0] REG_NORM = 2'd2;

   localparam logic [G_W-1:0]    G_RESET    = 18'd16384;
   localparam logic [DAMP_W-1:0] DAMP_RESET = 18'd81920;
   localparam logic [NORM_W-1:0] NORM_RESET = 17'd51200;

   typedef struct packed {
      logic [G_W-1:0]    g;
      logic [DAMP_W-1:0] damp;
      logic [NORM_W-1:0] norm;
   } coef_type;

   // Sequencer operations.
   localparam logic [1:0] SEQ_NEXT     = 2'd0;
   localparam logic [1:0] SEQ_WAIT_IN  = 2'd1;
   localparam logic [1:0] SEQ_WAIT_OUT = 2'd2;

   // Multiplier operand A selects.
   localparam logic [1:0] A_S1  = 2'd0;
   localparam logic [1:0] A_ACC = 2'd1;
   localparam logic [1:0] A_HP  = 2'd2;
   localparam logic [1:0] A_BP  = 2'd3;

   // Multiplier operand B (coefficient) selects.
   localparam logic [1:0] B_DAMP = 2'd0;
   localparam logic [1:0] B_NORM = 2'd1;
   localparam logic [1:0] B_G    = 2'd2;

   // Post-multiply operations.
   localparam logic [2:0] ALU_NONE = 3'd0;
   localparam logic [2:0] ALU_ACC  = 3'd1;
   localparam logic [2:0] ALU_HP   = 3'd2;
   localparam logic [2:0] ALU_BP   = 3'd3;
   localparam logic [2:0] ALU_LP   = 3'd4;
   localparam logic [2:0] ALU_S2   = 3'd5;

   typedef struct packed {
      logic [1:0] seq_op;
      logic [1:0] a_sel;
      logic [1:0] b_sel;
      logic       mul_en;
      logic [2:0] alu_op;
   } uword_type;

   typedef struct packed {
      logic [1:0] a_sel;
      logic [1:0] b_sel;
      logic       mul_en;
      logic [2:0] alu_op;
      logic       in_take;
      logic       out_load;
   } ctrl_type;

   localparam int UCODE_DEPTH = 9;
   localparam int UPC_W       = $clog2(UCODE_DEPTH);

   // The filter program. One word per step.
   function automatic uword_type ucode_rom(input logic [UPC_W-1:0] addr);
      uword_type w;
      w = '{seq_op: SEQ_NEXT, a_sel: A_S1, b_sel: B_DAMP, mul_en: 1'b0, alu_op: ALU_NONE};
      case (addr)
         4'd0: w = '{seq_op: SEQ_WAIT_IN, a_sel: A_S1, b_sel: B_DAMP,
                     mul_en: 1'b1, alu_op: ALU_NONE};
         4'd1: w = '{seq_op: SEQ_NEXT, a_sel: A_S1, b_sel: B_DAMP,
                     mul_en: 1'b0, alu_op: ALU_ACC};
         4'd2: w = '{seq_op: SEQ_NEXT, a_sel: A_ACC, b_sel: B_NORM,
                     mul_en: 1'b1, alu_op: ALU_NONE};
         4'd3: w = '{seq_op: SEQ_NEXT, a_sel: A_ACC, b_sel: B_NORM,
                     mul_en: 1'b0, alu_op: ALU_HP};
         4'd4: w = '{seq_op: SEQ_NEXT, a_sel: A_HP, b_sel: B_G,
                     mul_en: 1'b1, alu_op: ALU_NONE};
         4'd5: w = '{seq_op: SEQ_NEXT, a_sel: A_HP, b_sel: B_G,
                     mul_en: 1'b0, alu_op: ALU_BP};
         4'd6: w = '{seq_op: SEQ_NEXT, a_sel: A_BP, b_sel: B_G,
                     mul_en: 1'b1, alu_op: ALU_NONE};
         4'd7: w = '{seq_op: SEQ_NEXT, a_sel: A_BP, b_sel: B_G,
                     mul_en: 1'b0, alu_op: ALU_LP};
         4'd8: w = '{seq_op: SEQ_WAIT_OUT, a_sel: A_BP, b_sel: B_G,
                     mul_en: 1'b0, alu_op: ALU_S2};
         default: w = '{seq_op: SEQ_WAIT_OUT, a_sel: A_S1, b_sel: B_DAMP,
                        mul_en: 1'b0, alu_op: ALU_NONE};
      endcase
      return w;
   endfunction

endpackage

// ----- sv/svft_csr.sv -----
// Coefficient registers behind the APB-style configuration port.
module svft_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [svft_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [svft_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [svft_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                             pready,
   output svft_pkg::coef_type               coef
);
   import svft_pkg::*;

   coef_type              coef_ff, coef_in;
   logic [REG_IDX_W-1:0]  reg_idx;
   logic                  wr_en;

   assign pready  = 1'b1;
   assign reg_idx = paddr[CSR_ADDR_W-1:2];
   assign wr_en   = psel && penable && pwrite;

   always_comb begin
      coef_in = coef_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_G:    coef_in.g    = pwdata[G_W-1:0];
            REG_DAMP: coef_in.damp = pwdata[DAMP_W-1:0];
            REG_NORM: coef_in.norm = pwdata[NORM_W-1:0];
            default:  coef_in = coef_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_G:    prdata = CSR_DATA_W'(coef_ff.g);
         REG_DAMP: prdata = CSR_DATA_W'(coef_ff.damp);
         REG_NORM: prdata = CSR_DATA_W'(coef_ff.norm);
         default:  prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff <= '{g: G_RESET, damp: DAMP_RESET, norm: NORM_RESET};
      end else begin
         coef_ff <= coef_in;
      end
   end

   assign coef = coef_ff;

endmodule

// ----- sv/svft_sequencer.sv -----
// Microprogram sequencer: step counter, control store and conditional jumps.
module svft_sequencer (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                out_free,
   output logic                req_ready,
   output svft_pkg::ctrl_type  ctrl
);
   import svft_pkg::*;

   logic [UPC_W-1:0] upc_ff, upc_in;
   uword_type        uword;

   assign uword = ucode_rom(upc_ff);

   // Wait steps hold the counter until their handshake condition is met.
   always_comb begin
      case (uword.seq_op)
         SEQ_NEXT:     upc_in = upc_ff + 1'b1;
         SEQ_WAIT_IN:  upc_in = req_valid ? upc_ff + 1'b1 : upc_ff;
         SEQ_WAIT_OUT: upc_in = out_free ? '0 : upc_ff;
         default:      upc_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= '0;
      end else begin
         upc_ff <= upc_in;
      end
   end

   assign req_ready     = (uword.seq_op == SEQ_WAIT_IN);
   assign ctrl.a_sel    = uword.a_sel;
   assign ctrl.b_sel    = uword.b_sel;
   assign ctrl.mul_en   = uword.mul_en;
   assign ctrl.alu_op   = uword.alu_op;
   assign ctrl.in_take  = (uword.seq_op == SEQ_WAIT_IN) && req_valid;
   assign ctrl.out_load = (uword.seq_op == SEQ_WAIT_OUT) && out_free;

endmodule

// ----- sv/svft_datapath.sv -----
// Filter datapath: shared coefficient multiplier, rounding, adders and saturation.
module svft_datapath #(
   parameter int SAMPLE_WIDTH   = svft_pkg::SAMPLE_WIDTH_DEF,
   parameter int COEF_FRAC_BITS = svft_pkg::COEF_FRAC_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  svft_pkg::ctrl_type             ctrl,
   input  svft_pkg::coef_type             coef,
   input  logic signed [SAMPLE_WIDTH-1:0] sample,
   output logic signed [SAMPLE_WIDTH-1:0] lowpass,
   output logic signed [SAMPLE_WIDTH-1:0] bandpass,
   output logic signed [SAMPLE_WIDTH-1:0] highpass
);
   import svft_pkg::*;

   // A state times a coefficient, rounded, fits in CM_W signed bits.
   localparam int CM_W   = STATE_W + COEF_W + 1 - COEF_FRAC_BITS;
   localparam int BASE_W = (CM_W > STATE_W)
                           ? ((CM_W > SAMPLE_WIDTH) ? CM_W : SAMPLE_WIDTH)
                           : ((STATE_W > SAMPLE_WIDTH) ? STATE_W : SAMPLE_WIDTH);
   localparam int ACC_W  = BASE_W + 2;
   localparam int PROD_W = ACC_W + COEF_W + 1;
   localparam int RND_W  = PROD_W - COEF_FRAC_BITS;
   localparam int SUM_W  = ((RND_W > ACC_W) ? RND_W : ACC_W) + 2;
   localparam logic [PROD_W-1:0] RND_HALF =
      {{(PROD_W-1){1'b0}}, 1'b1} << (COEF_FRAC_BITS - 1);

   logic signed [SAMPLE_WIDTH-1:0] x_ff;
   logic signed [STATE_W-1:0]      s1_ff, s1_in, s2_ff, s2_in;
   logic signed [STATE_W-1:0]      hp_ff, hp_in, bp_ff, bp_in, lp_ff, lp_in;
   logic signed [ACC_W-1:0]        acc_ff, acc_in, mul_a;
   logic signed [CM_W-1:0]         ghp_ff, ghp_in;
   logic        [COEF_W-1:0]       mul_b;
   logic signed [PROD_W-1:0]       prod_ff, prod_in, prod_rnd;
   logic signed [RND_W-1:0]        cm;
   logic signed [SUM_W-1:0]        acc_sum;

   function automatic logic signed [STATE_W-1:0] sat_state(input logic signed [SUM_W-1:0] v);
      logic [SUM_W-STATE_W:0] top_bits;
      top_bits = v[SUM_W-1:STATE_W-1];
      if ((&top_bits) || (~|top_bits)) begin
         return v[STATE_W-1:0];
      end else if (v[SUM_W-1]) begin
         return {1'b1, {(STATE_W-1){1'b0}}};
      end else begin
         return {1'b0, {(STATE_W-1){1'b1}}};
      end
   endfunction

   function automatic logic signed [SAMPLE_WIDTH-1:0] sat_out(
      input logic signed [STATE_W-1:0] v);
      logic [STATE_W-SAMPLE_WIDTH:0] top_bits;
      top_bits = v[STATE_W-1:SAMPLE_WIDTH-1];
      if ((&top_bits) || (~|top_bits)) begin
         return v[SAMPLE_WIDTH-1:0];
      end else if (v[STATE_W-1]) begin
         return {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
      end else begin
         return {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
      end
   endfunction

   always_comb begin
      case (ctrl.a_sel)
         A_S1:    mul_a = ACC_W'(s1_ff);
         A_ACC:   mul_a = acc_ff;
         A_HP:    mul_a = ACC_W'(hp_ff);
         A_BP:    mul_a = ACC_W'(bp_ff);
         default: mul_a = '0;
      endcase
      case (ctrl.b_sel)
         B_DAMP:  mul_b = coef.damp;
         B_NORM:  mul_b = COEF_W'(coef.norm);
         B_G:     mul_b = coef.g;
         default: mul_b = '0;
      endcase
   end

   assign prod_in  = mul_a * $signed({1'b0, mul_b});
   // Round to nearest with ties upward: add half an LSB, then shift arithmetically.
   assign prod_rnd = prod_ff + $signed(RND_HALF);
   assign cm       = prod_rnd[PROD_W-1:COEF_FRAC_BITS];
   assign acc_sum  = SUM_W'(x_ff) - SUM_W'(cm) - SUM_W'(s2_ff);

   always_comb begin
      acc_in = acc_ff;
      hp_in  = hp_ff;
      bp_in  = bp_ff;
      lp_in  = lp_ff;
      ghp_in = ghp_ff;
      s1_in  = s1_ff;
      s2_in  = s2_ff;
      case (ctrl.alu_op)
         ALU_ACC: acc_in = acc_sum[ACC_W-1:0];
         ALU_HP:  hp_in  = sat_state(SUM_W'(cm));
         ALU_BP: begin
            ghp_in = cm[CM_W-1:0];
            bp_in  = sat_state(SUM_W'(cm) + SUM_W'(s1_ff));
         end
         ALU_LP: begin
            lp_in = sat_state(SUM_W'(cm) + SUM_W'(s2_ff));
            s1_in = sat_state(SUM_W'(ghp_ff) + SUM_W'(bp_ff));
         end
         ALU_S2:  s2_in = sat_state(SUM_W'(cm) + SUM_W'(lp_ff));
         default: acc_in = acc_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff <= '0;
         s2_ff <= '0;
      end else begin
         s1_ff <= s1_in;
         s2_ff <= s2_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.in_take) begin
         x_ff <= sample;
      end
      if (ctrl.mul_en) begin
         prod_ff <= prod_in;
      end
      acc_ff <= acc_in;
      hp_ff  <= hp_in;
      bp_ff  <= bp_in;
      lp_ff  <= lp_in;
      ghp_ff <= ghp_in;
   end

   assign lowpass  = sat_out(lp_ff);
   assign bandpass = sat_out(bp_ff);
   assign highpass = sat_out(hp_ff);

endmodule

// ----- sv/state_variable_filter_tpt_core.sv -----
// Top level of the trapezoidal state variable filter core.
//
// This core runs a zero-delay-feedback state variable filter on one signed
// sample per transfer and returns lowpass, bandpass and highpass together in
// one result transfer. Software loads three unsigned fixed-point coefficients
// over the APB-style port: g at byte address 0, the damping term 2R+g at
// address 4 and the normalizer 1/(1+2Rg+g^2) at address 8; writes to address
// 12 are dropped and read back as zero. Coefficients are to be written only
// while the core is idle; the core itself does not enforce this. Every
// coefficient product rounds to nearest with ties upward, the highpass,
// bandpass and lowpass values and both integrator states saturate to 32
// bits, and the outputs saturate to the sample width. From a sample's
// transfer to its result being loaded into the output register, a small
// microprogram drives a single shared coefficient multiplier four times in
// sequence, each product registered before the following add and saturate
// step. The core takes a new sample in the cycle after a result is loaded,
// never while an earlier sample is still in work; a result that is not
// taken holds the program at its last step.
module state_variable_filter_tpt_core #(
   parameter int SAMPLE_WIDTH   = svft_pkg::SAMPLE_WIDTH_DEF,
   parameter int COEF_FRAC_BITS = svft_pkg::COEF_FRAC_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // Sample channel.
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic signed [SAMPLE_WIDTH-1:0]  req_sample_in,
   // Result channel.
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic signed [SAMPLE_WIDTH-1:0]  rsp_lowpass_out,
   output logic signed [SAMPLE_WIDTH-1:0]  rsp_bandpass_out,
   output logic signed [SAMPLE_WIDTH-1:0]  rsp_highpass_out,
   // Configuration port.
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [svft_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [svft_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [svft_pkg::CSR_DATA_W-1:0] prdata,
   output logic                            pready
);
   import svft_pkg::*;

   coef_type                       coef;
   ctrl_type                       ctrl;
   logic                           out_free;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_WIDTH-1:0] lowpass, bandpass, highpass;
   logic signed [SAMPLE_WIDTH-1:0] lp_out_ff, bp_out_ff, hp_out_ff;

   svft_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .coef    (coef)
   );

   svft_sequencer u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .out_free  (out_free),
      .req_ready (req_ready),
      .ctrl      (ctrl)
   );

   svft_datapath #(
      .SAMPLE_WIDTH   (SAMPLE_WIDTH),
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (ctrl),
      .coef     (coef),
      .sample   (req_sample_in),
      .lowpass  (lowpass),
      .bandpass (bandpass),
      .highpass (highpass)
   );

   // The output register frees up in the same cycle its result transfer completes.
   assign out_free     = !rsp_valid_ff || rsp_ready;
   assign rsp_valid_in = ctrl.out_load || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.out_load) begin
         lp_out_ff <= lowpass;
         bp_out_ff <= bandpass;
         hp_out_ff <= highpass;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_lowpass_out  = lp_out_ff;
   assign rsp_bandpass_out = bp_out_ff;
   assign rsp_highpass_out = hp_out_ff;

endmodule
